>>> rtl/core/sqr_pkg.sv
package sqr_pkg;

    // Store geometry and burst limit.
    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int MAX_BURST  = 64;

    // Derived widths: pointers must hold the value DEPTH itself.
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 9;
    localparam int CNT_W  = 7;
    localparam int KIND_W = 2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Operation codes carried on the input tuser.
    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_ALL = 2'd2;

    // Capacity as used: zero acts as one, anything above DEPTH acts as DEPTH.
    function automatic ptr_t eff_cap(logic [CAP_W-1:0] c);
        ptr_t r;
        if (c == '0)
        begin
            r = ptr_t'(1);
        end
        else if (PTR_W'(c) > ptr_t'(DEPTH) || CAP_W > PTR_W && (c >> PTR_W) != '0)
        begin
            r = ptr_t'(DEPTH);
        end
        else
        begin
            r = ptr_t'(c);
        end
        return r;
    endfunction

    // Read pointer after the wrap that a pop applies first.
    function automatic ptr_t pop_base(ptr_t rp, ptr_t cap);
        return (rp == cap) ? '0 : rp;
    endfunction

    // Pop succeeds from an already wrapped read pointer.
    function automatic logic pop_can(ptr_t rb, ptr_t wp, ptr_t cap);
        return ((rb < cap) && (wp < rb)) || (rb < wp);
    endfunction

endpackage

>>> rtl/core/sqr_ram.sv
module sqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/spsc_ring_queue.sv
// Single-producer single-consumer ring queue over a 256 x 32 slot RAM, with
// a write and a read pointer that run from 0 to the programmed capacity.
// Each input transfer is a push, a single pop or a pop-all (tuser selects);
// every transfer yields one result, a pop-all one result per popped element
// with tlast on the final one. The block takes one item at a time: a push
// or an unknown kind goes from accept straight to the result state; a pop
// or pop-all passes through a RAM read state, then a result state, for every
// popped element, or once when nothing is popped, and the result state holds
// while the consumer keeps m_tready low. Each element needs the read state as
// the slot RAM read port is registered. Capacity is written through cfg_wr_en/
// cfg_wr_data; the user must write it only while the queue is idle, which the
// block itself does not enforce; zero acts as one and values above 256 act as
// 256. Slots read before ever being written return unspecified data.
module spsc_ring_queue (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // push_data [31:0], pop_limit [38:32], zero [39]
    input  logic [1:0]  s_tuser,   // kind [1:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // ok [0], pop_data [32:1], popped_count [39:33]
    output logic        m_tlast,
    // Capacity register.
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]                        state_reg, state_next;
    sqr_pkg::ptr_t                     wp_reg, wp_next;
    sqr_pkg::ptr_t                     rp_reg, rp_next;
    logic [sqr_pkg::CAP_W-1:0]         cap_reg;
    sqr_pkg::cnt_t                     limit_reg, limit_next;
    sqr_pkg::cnt_t                     count_reg, count_next;
    logic                              ok_reg, ok_next;
    logic                              last_reg, last_next;
    logic                              sel_reg, sel_next;

    sqr_pkg::ptr_t                     cap;
    sqr_pkg::ptr_t                     wp_w;
    logic                              wp_wrap, push_blocked, push_ok;
    sqr_pkg::ptr_t                     rp_a, rp_after;
    logic                              pop_ok, next_ok, attempt;
    sqr_pkg::cnt_t                     count_inc;
    sqr_pkg::cnt_t                     sat_limit;

    logic                              ram_wr_en, ram_rd_en;
    logic [sqr_pkg::DATA_WIDTH-1:0]    ram_rd_data;

    logic                              s_xfer, m_xfer;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = last_reg;
    assign m_tdata  = {count_reg, (sel_reg ? ram_rd_data : '0), ok_reg};

    assign cap = sqr_pkg::eff_cap(cap_reg);

    // Push decision: wrap the write pointer at capacity when the reader moved on.
    assign wp_wrap      = (wp_reg == cap) && (rp_reg > sqr_pkg::ptr_t'(1));
    assign push_blocked = (wp_reg == cap) && !wp_wrap;
    assign wp_w         = wp_wrap ? '0 : wp_reg;
    assign push_ok      = !push_blocked &&
                          (((wp_w < cap) && (rp_reg <= wp_w)) ||
                           ({1'b0, wp_w} + 1'b1 < {1'b0, rp_reg}));

    // Pop decision and a look-ahead at whether the following pop would succeed.
    assign rp_a      = sqr_pkg::pop_base(rp_reg, cap);
    assign pop_ok    = sqr_pkg::pop_can(rp_a, wp_reg, cap);
    assign rp_after  = rp_a + 1'b1;
    assign next_ok   = sqr_pkg::pop_can(sqr_pkg::pop_base(rp_after, cap), wp_reg, cap);
    assign attempt   = (count_reg < limit_reg);
    assign count_inc = count_reg + 1'b1;

    // Pop-all limit saturates at the burst size.
    assign sat_limit = (s_tdata[38:32] > sqr_pkg::cnt_t'(sqr_pkg::MAX_BURST)) ?
                       sqr_pkg::cnt_t'(sqr_pkg::MAX_BURST) : s_tdata[38:32];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        limit_next = limit_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        last_next  = last_reg;
        sel_next   = sel_reg;
        ram_wr_en  = 1'b0;
        ram_rd_en  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    count_next = '0;
                    sel_next   = 1'b0;
                    ok_next    = 1'b0;
                    last_next  = 1'b1;
                    unique case (s_tuser)
                        sqr_pkg::KIND_PUSH:
                        begin
                            ok_next    = push_ok;
                            ram_wr_en  = push_ok;
                            wp_next    = push_ok ? wp_w + 1'b1 : wp_w;
                            state_next = ST_OUT;
                        end
                        sqr_pkg::KIND_POP:
                        begin
                            limit_next = sqr_pkg::cnt_t'(1);
                            state_next = ST_POP;
                        end
                        sqr_pkg::KIND_POP_ALL:
                        begin
                            limit_next = sat_limit;
                            state_next = ST_POP;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                state_next = ST_OUT;
                if (attempt)
                begin
                    rp_next = pop_ok ? rp_after : rp_a;
                end
                if (attempt && pop_ok)
                begin
                    ram_rd_en  = 1'b1;
                    ok_next    = 1'b1;
                    sel_next   = 1'b1;
                    count_next = count_inc;
                    last_next  = (count_inc == limit_reg) || !next_ok;
                end
                else
                begin
                    ok_next    = 1'b0;
                    sel_next   = 1'b0;
                    count_next = '0;
                    last_next  = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (m_xfer)
                begin
                    state_next = last_reg ? ST_IDLE : ST_POP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            cap_reg   <= sqr_pkg::CAP_W'(sqr_pkg::DEPTH);
            limit_reg <= '0;
            count_reg <= '0;
            ok_reg    <= 1'b0;
            last_reg  <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            limit_reg <= limit_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
            last_reg  <= last_next;
            sel_reg   <= sel_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Slot store.
    sqr_ram #(
        .WIDTH (sqr_pkg::DATA_WIDTH),
        .DEPTH (sqr_pkg::DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_w[sqr_pkg::ADDR_W-1:0]),
        .wr_data (s_tdata[sqr_pkg::DATA_WIDTH-1:0]),
        .rd_en   (ram_rd_en),
        .rd_addr (rp_a[sqr_pkg::ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

`ifndef ASSERT_OFF
    // Pointers never pass the store depth.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= sqr_pkg::ptr_t'(sqr_pkg::DEPTH)) &&
        (rp_reg <= sqr_pkg::ptr_t'(sqr_pkg::DEPTH)))
        else $error("queue pointer beyond store depth");

    // A refused operation always ends its run.
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !ok_reg |-> m_tlast)
        else $error("failed result not marked last");

    // A burst never pops more than its limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sel_reg |-> (count_reg <= limit_reg) && (count_reg != '0))
        else $error("popped count outside the burst limit");

    // Input and result sides are never open together.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // A non-final pop result is followed by the next pop, which must succeed.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && !m_tlast |=> (state_reg == ST_POP) && attempt && pop_ok)
        else $error("burst continuation lost or look-ahead wrong");
`endif

endmodule
